[sv/udp_receive_checksum_port_match_top_assert.svh]
// assertion macros for the udp receive checksum and port match block
// no dependencies; used by the top level only
`ifndef UDP_RECEIVE_CHECKSUM_PORT_MATCH_TOP_ASSERT_SVH
`define UDP_RECEIVE_CHECKSUM_PORT_MATCH_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define UDP_RCM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("udp_rcm assertion failed");

// next-cycle implication
`define UDP_RCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("udp_rcm assertion failed");

`else

`define UDP_RCM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define UDP_RCM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[sv/udp_rcm_pkg.sv]
// shared types and constants for the udp receive checksum and port match block
// no dependencies
package udp_rcm_pkg;

	localparam int PORT_ENTRIES = 8;
	localparam int ENTRY_IDX_W  = (PORT_ENTRIES > 1) ? $clog2(PORT_ENTRIES) : 1;

	localparam logic [15:0] PROTO_UDP   = 16'd17;
	localparam logic [15:0] UDP_HDR_LEN = 16'd8;
	localparam logic [15:0] IDX_CSUM_HI = 16'd6;
	localparam logic [15:0] IDX_CSUM_LO = 16'd7;
	localparam logic [15:0] IDX_SPORT_HI = 16'd0;
	localparam logic [15:0] IDX_SPORT_LO = 16'd1;
	localparam logic [15:0] IDX_DPORT_HI = 16'd2;
	localparam logic [15:0] IDX_DPORT_LO = 16'd3;
	localparam logic [15:0] IDX_LIMIT   = 16'hFFFF;

	typedef enum logic [1:0] {
		CMD_BYTE  = 2'd0,
		CMD_OPEN  = 2'd1,
		CMD_CLOSE = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_SHORT    = 3'd1,
		ST_BAD_CSUM = 3'd2,
		ST_NO_PORT  = 3'd3,
		ST_OVERSIZE = 3'd4,
		ST_FULL     = 3'd5
	} status_t;

	localparam logic KIND_VERDICT = 1'b0;
	localparam logic KIND_ACK     = 1'b1;

	typedef struct packed {
		logic        open;
		logic        close;
		logic [15:0] port;
		logic [3:0]  handler;
	} tbl_req_t;

	typedef struct packed {
		logic       hit;
		logic       full;
		logic [3:0] handler;
	} tbl_rsp_t;

	typedef struct packed {
		logic        oversize;
		logic        too_short;
		logic        csum_ok;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [15:0] plen;
	} dg_verdict_t;

endpackage

[sv/udp_rcm_port_table.sv]
// open port table: parallel lookup, open and close edits
// depends on udp_rcm_pkg
module udp_rcm_port_table (
	input  logic                clk,
	input  logic                arst_n,
	input  udp_rcm_pkg::tbl_req_t req,
	output udp_rcm_pkg::tbl_rsp_t rsp
);
	import udp_rcm_pkg::*;

	logic [PORT_ENTRIES-1:0] valid_q;
	logic [15:0]             port_q    [PORT_ENTRIES];
	logic [3:0]              handler_q [PORT_ENTRIES];

	logic [PORT_ENTRIES-1:0] hit_vec;
	logic [ENTRY_IDX_W-1:0]  hit_idx;
	logic [ENTRY_IDX_W-1:0]  free_idx;
	logic [ENTRY_IDX_W-1:0]  wr_idx;
	logic                    any_free;
	logic [3:0]              hit_handler;
	logic                    do_write;

	always_comb begin
		hit_idx     = '0;
		free_idx    = '0;
		any_free    = 1'b0;
		hit_handler = '0;
		for (int i = 0; i < PORT_ENTRIES; i++) begin
			hit_vec[i] = valid_q[i] && (port_q[i] == req.port);
			// ports are unique in the table, so an or of the masked handlers is the match
			if (hit_vec[i]) begin
				hit_handler = hit_handler | handler_q[i];
			end
		end
		// lowest index wins
		for (int i = PORT_ENTRIES - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				hit_idx = ENTRY_IDX_W'(i);
			end
			if (!valid_q[i]) begin
				free_idx = ENTRY_IDX_W'(i);
				any_free = 1'b1;
			end
		end
	end

	assign wr_idx      = (|hit_vec) ? hit_idx : free_idx;
	assign rsp.hit     = |hit_vec;
	assign rsp.full    = !(|hit_vec) && !any_free;
	assign rsp.handler = hit_handler;
	assign do_write    = req.open && !rsp.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (do_write) begin
			valid_q[wr_idx] <= 1'b1;
		end else if (req.close) begin
			valid_q <= valid_q & ~hit_vec;
		end
	end

	always_ff @(posedge clk) begin
		if (do_write) begin
			port_q[wr_idx]    <= req.port;
			handler_q[wr_idx] <= req.handler;
		end
	end

endmodule

[sv/udp_rcm_dgram.sv]
// datagram byte accumulator: header capture, running ones' complement sum and verdict terms
// depends on udp_rcm_pkg
module udp_rcm_dgram (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [7:0]             data_byte,
	input  logic                   last_byte,
	input  logic [31:0]            source_address,
	input  logic [31:0]            local_ip,
	output udp_rcm_pkg::dg_verdict_t verdict
);
	import udp_rcm_pkg::*;

	logic [15:0] byte_count_q;
	logic        too_long_q;
	logic [15:0] running_sum_q;
	logic [7:0]  held_high_q;
	logic [15:0] rx_csum_q;
	logic [15:0] src_port_q;
	logic [15:0] dst_port_q;
	logic [31:0] src_ip_q;

	logic        at_limit;
	logic        active;
	logic [7:0]  v;
	logic [15:0] cur_word;
	logic [16:0] step_sum;
	logic [15:0] sum_next;
	logic [15:0] n_new;
	logic [18:0] total;
	logic [16:0] fold1;
	logic [15:0] fold2;
	logic [15:0] calc;
	logic [15:0] rx_csum;

	assign at_limit = (byte_count_q == IDX_LIMIT);
	assign active   = !too_long_q && !at_limit;
	// checksum field bytes count as zero
	assign v = ((byte_count_q == IDX_CSUM_HI) || (byte_count_q == IDX_CSUM_LO)) ? 8'h00
		: data_byte;
	// odd index completes a word; even index is a zero padded tail if it is the last
	assign cur_word = byte_count_q[0] ? {held_high_q, v} : {v, 8'h00};
	assign step_sum = {1'b0, running_sum_q} + {1'b0, cur_word};
	assign sum_next = step_sum[15:0] + {15'b0, step_sum[16]};
	assign n_new    = byte_count_q + 16'd1;

	// end-around carry sum over the pseudo-header and the last word in one go
	assign total = 19'(running_sum_q) + 19'(cur_word)
		+ 19'(src_ip_q[31:16]) + 19'(src_ip_q[15:0])
		+ 19'(local_ip[31:16]) + 19'(local_ip[15:0])
		+ 19'(PROTO_UDP) + 19'(n_new);
	assign fold1 = {1'b0, total[15:0]} + {14'b0, total[18:16]};
	assign fold2 = fold1[15:0] + {15'b0, fold1[16]};
	assign calc  = ~fold2;

	assign rx_csum = (byte_count_q == IDX_CSUM_LO) ? {rx_csum_q[15:8], data_byte} : rx_csum_q;

	assign verdict.oversize  = !active;
	assign verdict.too_short = n_new < UDP_HDR_LEN;
	assign verdict.csum_ok   = (rx_csum == calc) || (rx_csum == 16'h0000)
		|| ((calc == 16'h0000) && (rx_csum == 16'hFFFF));
	assign verdict.sport     = src_port_q;
	assign verdict.dport     = dst_port_q;
	assign verdict.plen      = n_new - UDP_HDR_LEN;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q  <= '0;
			too_long_q    <= 1'b0;
			running_sum_q <= '0;
			held_high_q   <= '0;
			rx_csum_q     <= '0;
			src_port_q    <= '0;
			dst_port_q    <= '0;
			src_ip_q      <= '0;
		end else if (step) begin
			if (last_byte) begin
				byte_count_q  <= '0;
				too_long_q    <= 1'b0;
				running_sum_q <= '0;
				held_high_q   <= '0;
				rx_csum_q     <= '0;
				src_port_q    <= '0;
				dst_port_q    <= '0;
				src_ip_q      <= '0;
			end else if (active) begin
				byte_count_q <= n_new;
				if (byte_count_q[0]) begin
					running_sum_q <= sum_next;
				end else begin
					held_high_q <= v;
				end
				if (byte_count_q == IDX_SPORT_HI) begin
					src_ip_q          <= source_address;
					src_port_q[15:8]  <= data_byte;
				end
				if (byte_count_q == IDX_SPORT_LO) begin
					src_port_q[7:0] <= data_byte;
				end
				if (byte_count_q == IDX_DPORT_HI) begin
					dst_port_q[15:8] <= data_byte;
				end
				if (byte_count_q == IDX_DPORT_LO) begin
					dst_port_q[7:0] <= data_byte;
				end
				if (byte_count_q == IDX_CSUM_HI) begin
					rx_csum_q[15:8] <= data_byte;
				end
				if (byte_count_q == IDX_CSUM_LO) begin
					rx_csum_q[7:0] <= data_byte;
				end
			end else if (!too_long_q) begin
				too_long_q <= 1'b1;
			end
		end
	end

endmodule

[sv/udp_receive_checksum_port_match_top.sv]
// an accepted transaction is held in the stage register, then its result in the result register
// throughput: one transaction per cycle; a held result stalls the input only when the
// stage register is also full
// reset clears the port table valid bits, the datagram state, local_ip and both stages
// depends on udp_rcm_pkg, udp_rcm_dgram, udp_rcm_port_table and the assertion header
module udp_receive_checksum_port_match_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        local_ip_we,
	input  logic [31:0] local_ip_wdata,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  cmd,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic [31:0] source_address,
	input  logic [15:0] port_number,
	input  logic [3:0]  handler_id,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        kind,
	output logic [2:0]  status,
	output logic [3:0]  target_handler,
	output logic [15:0] sender_port,
	output logic [15:0] receiver_port,
	output logic [15:0] payload_length
);
	import udp_rcm_pkg::*;

`include "udp_receive_checksum_port_match_top_assert.svh"

	logic [31:0] local_ip_q;

	logic        valid_s1;
	cmd_t        cmd_s1;
	logic [7:0]  data_s1;
	logic        last_s1;
	logic [31:0] src_s1;
	logic [15:0] port_s1;
	logic [3:0]  handler_s1;

	logic        res_valid_q;
	logic        kind_q;
	status_t     status_q;
	logic [3:0]  target_q;
	logic [15:0] sport_q;
	logic [15:0] dport_q;
	logic [15:0] plen_q;

	logic        advance;
	logic        accept_in;
	logic        fire;
	logic        is_byte;
	logic        is_open;
	logic        is_close;
	logic        produce;

	tbl_req_t    tbl_req;
	tbl_rsp_t    tbl_rsp;
	dg_verdict_t verdict;

	logic        kind_d;
	status_t     status_d;
	logic [3:0]  target_d;
	logic [15:0] sport_d;
	logic [15:0] dport_d;
	logic [15:0] plen_d;

	assign advance    = !res_valid_q || !result_stall;
	assign item_stall = valid_s1 && !advance;
	assign accept_in  = item_valid && !item_stall;
	assign fire       = valid_s1 && advance;
	assign is_byte    = (cmd_s1 == CMD_BYTE);
	assign is_open    = (cmd_s1 == CMD_OPEN);
	assign is_close   = (cmd_s1 == CMD_CLOSE);
	assign produce    = fire && (is_open || is_close || (is_byte && last_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_ip_q <= '0;
		end else if (local_ip_we) begin
			local_ip_q <= local_ip_wdata;
		end
	end

	// the stage loads whenever it is empty or moving on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			cmd_s1     <= cmd_t'(cmd);
			data_s1    <= data_byte;
			last_s1    <= last_byte;
			src_s1     <= source_address;
			port_s1    <= port_number;
			handler_s1 <= handler_id;
		end
	end

	// datagram bytes look up their destination port, commands their own port
	assign tbl_req.open    = fire && is_open;
	assign tbl_req.close   = fire && is_close;
	assign tbl_req.port    = is_byte ? verdict.dport : port_s1;
	assign tbl_req.handler = handler_s1;

	udp_rcm_port_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (tbl_req),
		.rsp    (tbl_rsp)
	);

	udp_rcm_dgram u_dgram (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (fire && is_byte),
		.data_byte      (data_s1),
		.last_byte      (last_s1),
		.source_address (src_s1),
		.local_ip       (local_ip_q),
		.verdict        (verdict)
	);

	always_comb begin
		kind_d   = KIND_VERDICT;
		status_d = ST_OK;
		target_d = '0;
		sport_d  = '0;
		dport_d  = '0;
		plen_d   = '0;
		if (!is_byte) begin
			kind_d  = KIND_ACK;
			dport_d = port_s1;
			if (is_open) begin
				target_d = handler_s1;
				status_d = tbl_rsp.full ? ST_FULL : ST_OK;
			end
		end else begin
			priority if (verdict.oversize) begin
				status_d = ST_OVERSIZE;
			end else if (verdict.too_short) begin
				status_d = ST_SHORT;
			end else begin
				sport_d = verdict.sport;
				dport_d = verdict.dport;
				plen_d  = verdict.plen;
				priority if (!verdict.csum_ok) begin
					status_d = ST_BAD_CSUM;
				end else if (!tbl_rsp.hit) begin
					status_d = ST_NO_PORT;
				end else begin
					status_d = ST_OK;
					target_d = tbl_rsp.handler;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= produce;
		end
	end

	always_ff @(posedge clk) begin
		if (produce) begin
			kind_q   <= kind_d;
			status_q <= status_d;
			target_q <= target_d;
			sport_q  <= sport_d;
			dport_q  <= dport_d;
			plen_q   <= plen_d;
		end
	end

	assign result_valid   = res_valid_q;
	assign kind           = kind_q;
	assign status         = status_q;
	assign target_handler = target_q;
	assign sender_port    = sport_q;
	assign receiver_port  = dport_q;
	assign payload_length = plen_q;

	`UDP_RCM_ASSERT_NOW(a_stall_cause, clk, arst_n, item_stall, res_valid_q && result_stall && valid_s1)
	`UDP_RCM_ASSERT_NEXT(a_cmd_acked, clk, arst_n, fire && (is_open || is_close), res_valid_q && (kind_q == KIND_ACK))
	`UDP_RCM_ASSERT_NEXT(a_mid_byte_quiet, clk, arst_n, fire && is_byte && !last_s1, !res_valid_q)
	`UDP_RCM_ASSERT_NOW(a_full_is_ack, clk, arst_n, res_valid_q && (status_q == ST_FULL), kind_q == KIND_ACK)

endmodule

[tb/udp_receive_checksum_port_match_top_test.sv]
// self-checking testbench for udp_receive_checksum_port_match_top: bytes and table commands
// are queued up front, driven with random gaps, and predicted transaction by transaction
// depends on udp_rcm_pkg and the top level with its submodules
`timescale 1ns / 100ps

module udp_receive_checksum_port_match_top_test;
	import udp_rcm_pkg::*;

	localparam int CYCLE_LIMIT    = 1000000;
	localparam int SETTLE_CYCLES  = 6;
	localparam int DRAIN_CYCLES   = 10;
	localparam int RANDOM_ITEMS   = 500;
	localparam int RANDOM_RESULTS = 60;
	localparam int POOL_SIZE      = 12;

	typedef enum int {CS_GOOD, CS_NONE, CS_BAD, CS_ALL_ONES} csum_mode_t;

	typedef struct {
		logic        is_cfg;
		logic [31:0] cfg_value;
		cmd_t        op;
		logic [7:0]  data;
		logic        last;
		logic [31:0] src;
		logic [15:0] port;
		logic [3:0]  handler;
		int          gap;
		logic        quiet;
	} stim_entry_t;

	typedef struct {
		logic        kind;
		status_t     status;
		logic [3:0]  handler;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [15:0] plen;
	} result_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        local_ip_we = 1'b0;
	logic [31:0] local_ip_wdata = '0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic [1:0]  cmd = CMD_NONE;
	logic [7:0]  data_byte = '0;
	logic        last_byte = 1'b0;
	logic [31:0] source_address = '0;
	logic [15:0] port_number = '0;
	logic [3:0]  handler_id = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic        kind;
	logic [2:0]  status;
	logic [3:0]  target_handler;
	logic [15:0] sender_port;
	logic [15:0] receiver_port;
	logic [15:0] payload_length;

	udp_receive_checksum_port_match_top uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.local_ip_we    (local_ip_we),
		.local_ip_wdata (local_ip_wdata),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.cmd            (cmd),
		.data_byte      (data_byte),
		.last_byte      (last_byte),
		.source_address (source_address),
		.port_number    (port_number),
		.handler_id     (handler_id),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.kind           (kind),
		.status         (status),
		.target_handler (target_handler),
		.sender_port    (sender_port),
		.receiver_port  (receiver_port),
		.payload_length (payload_length)
	);

	// pending transactions and the verdicts/acks they should produce
	stim_entry_t stim [$];
	result_t     verdicts_due [$];

	// mirror of the block: port table, datagram in progress, local address
	logic        slot_open [PORT_ENTRIES] = '{default: 1'b0};
	logic [15:0] slot_port [PORT_ENTRIES];
	logic [3:0]  slot_handler [PORT_ENTRIES];
	logic [15:0] rx_count = '0;
	logic        rx_overrun = 1'b0;
	logic [15:0] csum_acc = '0;
	logic [7:0]  pending_hi = '0;
	logic [15:0] rx_csum = '0;
	logic [15:0] rx_sport = '0;
	logic [15:0] rx_dport = '0;
	logic [31:0] rx_src_ip = '0;
	logic [31:0] model_local_ip = '0;

	// stimulus generation state
	logic [31:0] gen_local_ip = '0;
	logic        gen_noisy = 1'b1;
	int          gen_items = 0;
	int          gen_results = 0;
	logic [15:0] port_pool [POOL_SIZE];

	int failures = 0;
	int cycle_count = 0;
	int verdict_tally [6] = '{default: 0};
	int ack_count = 0;
	int full_count = 0;
	int cfg_writes = 0;
	logic quiet_sink = 1'b0;

	function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

	function automatic int find_open_slot(input logic [15:0] p);
		for (int i = 0; i < PORT_ENTRIES; i++)
			if (slot_open[i] && slot_port[i] == p)
				return i;
		return -1;
	endfunction

	function automatic void track_transaction(input stim_entry_t t);
		result_t     r;
		logic [7:0]  v;
		logic [15:0] sum;
		logic [15:0] calc;
		logic        match;
		int          slot;
		r.kind = KIND_ACK;
		r.status = ST_OK;
		r.handler = '0;
		r.sport = '0;
		r.dport = '0;
		r.plen = '0;
		case (t.op)
			CMD_OPEN, CMD_CLOSE: begin
				slot = find_open_slot(t.port);
				r.dport = t.port;
				if (t.op == CMD_OPEN) begin
					r.handler = t.handler;
					if (slot < 0) begin
						slot = 0;
						while (slot < PORT_ENTRIES && slot_open[slot])
							slot++;
					end
					if (slot < PORT_ENTRIES) begin
						slot_open[slot] = 1'b1;
						slot_port[slot] = t.port;
						slot_handler[slot] = t.handler;
					end else begin
						r.status = ST_FULL;
					end
				end else begin
					for (int i = 0; i < PORT_ENTRIES; i++)
						if (slot_open[i] && slot_port[i] == t.port)
							slot_open[i] = 1'b0;
				end
				verdicts_due.push_back(r);
			end
			CMD_BYTE: begin
				if (!rx_overrun) begin
					if (rx_count == IDX_LIMIT) begin
						rx_overrun = 1'b1;
					end else begin
						v = t.data;
						case (rx_count)
							IDX_SPORT_HI: begin
								rx_src_ip = t.src;
								rx_sport[15:8] = v;
							end
							IDX_SPORT_LO: rx_sport[7:0] = v;
							IDX_DPORT_HI: rx_dport[15:8] = v;
							IDX_DPORT_LO: rx_dport[7:0] = v;
							IDX_CSUM_HI: begin
								rx_csum[15:8] = v;
								v = '0;
							end
							IDX_CSUM_LO: begin
								rx_csum[7:0] = v;
								v = '0;
							end
							default: ;
						endcase
						if (!rx_count[0])
							pending_hi = v;
						else
							csum_acc = ones_add(csum_acc, {pending_hi, v});
						rx_count = rx_count + 16'd1;
					end
				end
				if (t.last) begin
					r.kind = KIND_VERDICT;
					if (rx_overrun) begin
						r.status = ST_OVERSIZE;
					end else if (rx_count < UDP_HDR_LEN) begin
						r.status = ST_SHORT;
					end else begin
						sum = csum_acc;
						// odd tail byte is padded with a zero low byte
						if (rx_count[0])
							sum = ones_add(sum, {pending_hi, 8'h00});
						sum = ones_add(sum, rx_src_ip[31:16]);
						sum = ones_add(sum, rx_src_ip[15:0]);
						sum = ones_add(sum, model_local_ip[31:16]);
						sum = ones_add(sum, model_local_ip[15:0]);
						sum = ones_add(sum, PROTO_UDP);
						sum = ones_add(sum, rx_count);
						calc = ~sum;
						match = rx_csum == calc || rx_csum == 16'h0000 ||
							(calc == 16'h0000 && rx_csum == 16'hFFFF);
						r.sport = rx_sport;
						r.dport = rx_dport;
						r.plen = rx_count - UDP_HDR_LEN;
						slot = find_open_slot(rx_dport);
						if (!match)
							r.status = ST_BAD_CSUM;
						else if (slot < 0)
							r.status = ST_NO_PORT;
						else
							r.handler = slot_handler[slot];
					end
					verdicts_due.push_back(r);
					rx_count = '0;
					rx_overrun = 1'b0;
					csum_acc = '0;
					pending_hi = '0;
					rx_csum = '0;
					rx_sport = '0;
					rx_dport = '0;
					rx_src_ip = '0;
				end
			end
			default: ;
		endcase
	endfunction

	// ---- stimulus building ----

	function automatic stim_entry_t make_entry(input cmd_t op);
		stim_entry_t e;
		e.is_cfg = 1'b0;
		e.cfg_value = '0;
		e.op = op;
		e.data = 8'($urandom_range(0, 255));
		e.last = 1'($urandom_range(0, 1));
		e.src = $urandom;
		e.port = 16'($urandom_range(0, 65535));
		e.handler = 4'($urandom_range(0, 15));
		e.gap = (gen_noisy && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
		e.quiet = !gen_noisy;
		return e;
	endfunction

	function automatic void push_byte(input logic [7:0] d, input logic l, input logic [31:0] s);
		stim_entry_t e;
		e = make_entry(CMD_BYTE);
		e.data = d;
		e.last = l;
		e.src = s;
		stim.push_back(e);
		gen_items++;
		if (l)
			gen_results++;
	endfunction

	function automatic void push_table(input cmd_t op, input logic [15:0] p,
			input logic [3:0] h);
		stim_entry_t e;
		e = make_entry(op);
		e.port = p;
		e.handler = h;
		stim.push_back(e);
		gen_items++;
		gen_results++;
	endfunction

	function automatic void push_config(input logic [31:0] value);
		stim_entry_t e;
		e = make_entry(CMD_NONE);
		e.is_cfg = 1'b1;
		e.cfg_value = value;
		e.gap = 0;
		stim.push_back(e);
		gen_local_ip = value;
	endfunction

	function automatic logic [15:0] pick_port();
		if ($urandom_range(0, 6) == 0)
			return 16'($urandom_range(0, 65535));
		return port_pool[$urandom_range(0, POOL_SIZE - 1)];
	endfunction

	function automatic logic [31:0] random_address();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic void queue_table_random();
		cmd_t op;
		op = ($urandom_range(0, 9) < 6) ? CMD_OPEN : CMD_CLOSE;
		push_table(op, pick_port(), 4'($urandom_range(0, 15)));
	endfunction

	// folded sum of datagram plus pseudo-header, checksum bytes already zeroed
	function automatic logic [15:0] datagram_sum(input logic [7:0] pkt [$],
			input logic [31:0] src);
		logic [15:0] acc;
		int n;
		n = pkt.size();
		acc = '0;
		for (int i = 0; i + 1 < n; i += 2)
			acc = ones_add(acc, {pkt[i], pkt[i + 1]});
		if (n % 2 == 1)
			acc = ones_add(acc, {pkt[n - 1], 8'h00});
		acc = ones_add(acc, src[31:16]);
		acc = ones_add(acc, src[15:0]);
		acc = ones_add(acc, gen_local_ip[31:16]);
		acc = ones_add(acc, gen_local_ip[15:0]);
		acc = ones_add(acc, PROTO_UDP);
		acc = ones_add(acc, n[15:0]);
		return acc;
	endfunction

	// cmd_at >= 0 slips a table command in after that byte, unless it is the last byte
	function automatic void queue_datagram(input int n, input logic [15:0] dport,
			input csum_mode_t mode, input int cmd_at);
		logic [7:0]  pkt [$];
		logic [31:0] src;
		logic [15:0] calc;
		logic [15:0] field;
		logic [15:0] w;
		src = random_address();
		for (int i = 0; i < n; i++)
			pkt.push_back(8'($urandom_range(0, 255)));
		if (n >= 8) begin
			pkt[2] = dport[15:8];
			pkt[3] = dport[7:0];
			pkt[6] = '0;
			pkt[7] = '0;
			case (mode)
				CS_GOOD: field = ~datagram_sum(pkt, src);
				CS_NONE: field = '0;
				CS_BAD: begin
					calc = ~datagram_sum(pkt, src);
					do
						field = 16'($urandom_range(1, 65535));
					while (field == calc || (calc == 16'h0000 && field == 16'hFFFF));
				end
				default: begin
					// tune the last word so the computed checksum comes out zero
					pkt[n - 2] = '0;
					pkt[n - 1] = '0;
					w = ~datagram_sum(pkt, src);
					pkt[n - 2] = w[15:8];
					pkt[n - 1] = w[7:0];
					field = 16'hFFFF;
				end
			endcase
			pkt[6] = field[15:8];
			pkt[7] = field[7:0];
		end
		for (int i = 0; i < n; i++) begin
			push_byte(pkt[i], i == n - 1, (i == 0) ? src : $urandom);
			if (i == cmd_at && i < n - 1)
				queue_table_random();
		end
	endfunction

	// ---- clock, stimulus, end of run ----

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin : stimulus
		int items_mark;
		int results_mark;
		int since_cfg;
		int cfg_round;
		int mark;
		int pick;
		int n;
		csum_mode_t mode;
		for (int i = 0; i < POOL_SIZE; i++)
			port_pool[i] = 16'($urandom_range(1, 65534));
		port_pool[0] = 16'h0000;
		port_pool[1] = 16'hFFFF;

		// directed: extremes, every command, each verdict except oversize
		push_config($urandom);
		push_table(CMD_OPEN, 16'h0000, 4'hF);
		push_table(CMD_OPEN, 16'hFFFF, 4'h0);
		queue_datagram(8, 16'h0000, CS_GOOD, -1);
		queue_datagram(9, 16'hFFFF, CS_GOOD, 4);
		queue_datagram(1, 16'h0000, CS_GOOD, -1);
		queue_datagram(7, 16'h0000, CS_GOOD, -1);
		queue_datagram(10, 16'hFFFF, CS_ALL_ONES, -1);
		queue_datagram(12, port_pool[5], CS_NONE, -1);
		queue_datagram(8, 16'h0000, CS_BAD, -1);
		stim.push_back(make_entry(CMD_NONE));
		for (int i = 2; i < 9; i++)
			push_table(CMD_OPEN, port_pool[i], 4'($urandom_range(0, 15)));
		push_table(CMD_OPEN, 16'h0000, 4'h3);
		push_table(CMD_CLOSE, port_pool[11], 4'h0);
		push_table(CMD_CLOSE, port_pool[2], 4'h0);
		push_table(CMD_OPEN, port_pool[9], 4'hA);

		// random: mostly well-formed datagrams, some broken ones, table churn
		items_mark = gen_items;
		results_mark = gen_results;
		since_cfg = 0;
		cfg_round = 0;
		while (gen_items - items_mark < RANDOM_ITEMS ||
				gen_results - results_mark < RANDOM_RESULTS) begin
			if ($urandom_range(0, 14) == 0)
				gen_noisy = !gen_noisy;
			if (since_cfg >= 150) begin
				case (cfg_round)
					0: push_config(32'hFFFF_FFFF);
					1: push_config(32'h0000_0000);
					default: push_config($urandom);
				endcase
				cfg_round++;
				since_cfg = 0;
			end
			mark = gen_items;
			pick = $urandom_range(0, 99);
			if (pick < 20) begin
				queue_table_random();
			end else if (pick < 24) begin
				stim.push_back(make_entry(CMD_NONE));
			end else if (pick < 32) begin
				queue_datagram($urandom_range(1, 7), pick_port(), CS_GOOD, -1);
			end else begin
				n = ($urandom_range(0, 6) == 0) ? $urandom_range(25, 80) : $urandom_range(8, 24);
				pick = $urandom_range(0, 99);
				if (pick < 5 && n >= 10 && n % 2 == 0)
					mode = CS_ALL_ONES;
				else if (pick < 70)
					mode = CS_GOOD;
				else if (pick < 80)
					mode = CS_NONE;
				else
					mode = CS_BAD;
				queue_datagram(n, pick_port(), mode,
					($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 2) : -1);
			end
			since_cfg += gen_items - mark;
		end

		// last part, no idling: table edits and a few short datagrams
		gen_noisy = 1'b0;
		push_config($urandom);
		for (int i = 2; i < 6; i++)
			push_table(CMD_CLOSE, port_pool[i], 4'h0);
		push_table(CMD_OPEN, 16'h1F90, 4'h9);
		queue_datagram(8, 16'h1F90, CS_GOOD, -1);
		queue_datagram(9, 16'hFFFF, CS_BAD, -1);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (stim.size() != 0 || item_valid || verdicts_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d verdicts: ok %0d, short %0d, bad checksum %0d, no port %0d",
			verdict_tally[ST_OK] + verdict_tally[ST_SHORT] + verdict_tally[ST_BAD_CSUM] +
			verdict_tally[ST_NO_PORT] + verdict_tally[ST_OVERSIZE],
			verdict_tally[ST_OK], verdict_tally[ST_SHORT], verdict_tally[ST_BAD_CSUM],
			verdict_tally[ST_NO_PORT]);
		$display("plus %0d table acks (%0d table full) and %0d local address writes",
			ack_count, full_count, cfg_writes);
		if (failures == 0)
			$display("udp_receive_checksum_port_match_top test passed");
		else
			$display("udp_receive_checksum_port_match_top test failed");
		$finish;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("udp_receive_checksum_port_match_top test failed");
			$finish;
		end
	end

	// ---- driver ----

	stim_entry_t held;
	int          gap_left = 0;
	logic        gap_armed = 1'b0;
	int          settle_count = 0;

	always @(posedge clk or negedge arst_n) begin : drive
		stim_entry_t head;
		logic        take;
		logic        nxt_valid;
		logic        nxt_we;
		if (!arst_n) begin
			item_valid <= 1'b0;
			local_ip_we <= 1'b0;
		end else begin
			take = !item_valid || !item_stall;
			if (item_valid && !item_stall)
				track_transaction(held);
			nxt_valid = item_valid && !take;
			nxt_we = 1'b0;
			if (verdicts_due.size() == 0 && !item_valid)
				settle_count++;
			else
				settle_count = 0;
			if (take && stim.size() != 0) begin
				head = stim[0];
				if (!gap_armed) begin
					gap_left = head.gap;
					gap_armed = 1'b1;
				end
				if (gap_left > 0) begin
					gap_left--;
				end else if (head.is_cfg) begin
					// only write the address once the pipeline has fully drained
					if (settle_count >= SETTLE_CYCLES) begin
						nxt_we = 1'b1;
						local_ip_wdata <= head.cfg_value;
						model_local_ip = head.cfg_value;
						cfg_writes++;
						void'(stim.pop_front());
						gap_armed = 1'b0;
						settle_count = 0;
					end
				end else begin
					held = head;
					void'(stim.pop_front());
					gap_armed = 1'b0;
					nxt_valid = 1'b1;
					cmd <= head.op;
					data_byte <= head.data;
					last_byte <= head.last;
					source_address <= head.src;
					port_number <= head.port;
					handler_id <= head.handler;
					quiet_sink <= head.quiet;
				end
			end
			item_valid <= nxt_valid;
			local_ip_we <= nxt_we;
		end
	end

	// ---- monitor ----

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endfunction

	int stall_left = 0;

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		logic    nxt_stall;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (verdicts_due.size() == 0) begin
					$error("result with nothing expected: kind %0d status %0d", kind, status);
					failures++;
				end else begin
					want = verdicts_due.pop_front();
					check_field("kind", want.kind, kind);
					check_field("status", want.status, status);
					check_field("target_handler", want.handler, target_handler);
					check_field("sender_port", want.sport, sender_port);
					check_field("receiver_port", want.dport, receiver_port);
					check_field("payload_length", want.plen, payload_length);
					if (want.kind == KIND_ACK) begin
						ack_count++;
						if (want.status == ST_FULL)
							full_count++;
					end else begin
						verdict_tally[want.status]++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				nxt_stall = 1'b1;
			end else if (!quiet_sink && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 18);
				nxt_stall = 1'b1;
			end else begin
				nxt_stall = 1'b0;
			end
			result_stall <= nxt_stall;
		end
	end

endmodule
